@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// expr must never hold at a clock edge outside reset
`define ASSERT_NEVER(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

@@ design/stm_pkg.sv @@
package stm_pkg;

   localparam int AMP_W = 24;
   localparam int THR_W = 23;
   localparam int SCALE_W = 16;
   localparam int D_W = 25;
   localparam int X_W = 42;
   localparam int T_W = 19;
   localparam int SPAN_SHIFT = 17;

   localparam int TABLE_ENTRIES_DEF = 256;
   localparam int WEIGHT_FRAC_BITS_DEF = 16;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 23;

   localparam logic [CSR_INDEX_W-1:0] REG_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SCALE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_HARD_MODE = 2'd2;

   localparam logic [THR_W-1:0] THRESHOLD_RST = 23'd1;
   localparam logic [SCALE_W-1:0] SCALE_RST = 16'd655;

   localparam logic signed [X_W-1:0] X_LIMIT = 42'sd196608;
   localparam logic signed [X_W-1:0] X_LIMIT_NEG = -42'sd196608;
   localparam logic [T_W-1:0] SPAN = 19'd393216;
   localparam logic [T_W-1:0] HALF_SPAN = 19'd196608;

   typedef logic [1:0] wcode_type;
   localparam wcode_type CODE_ZERO = 2'd0;
   localparam wcode_type CODE_ONE = 2'd1;
   localparam wcode_type CODE_TABLE = 2'd2;

   typedef struct packed {
      logic      last;
      wcode_type code;
   } ctrl_type;

   localparam logic [63:0] FX_ONE = 64'd1 << 30;
   localparam logic [63:0] FX_HALF = 64'd1 << 29;
   localparam logic [63:0] FX_MASK = (64'd1 << 30) - 64'd1;
   localparam longint FX_S = 64'sd1073741824;
   localparam int TAYLOR_TERMS = 24;

   function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] hi;
      logic [63:0] lo;
      hi = a >> 30;
      lo = a & FX_MASK;
      return hi * b + ((lo * b + FX_HALF) >> 30);
   endfunction

   function automatic logic [63:0] taylor(input logic [63:0] r, input logic neg);
      logic [63:0] sum;
      logic [63:0] term;
      sum = FX_ONE;
      term = FX_ONE;
      for (int k = 1; k <= TAYLOR_TERMS; k++) begin
         term = ((term * r + FX_HALF) >> 30) / 64'(k);
         if (neg && k[0]) begin
            sum = (term > sum) ? 64'd0 : sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return sum;
   endfunction

   function automatic logic [63:0] gompertz(input longint x);
      logic [63:0] e1;
      logic [63:0] einv;
      logic [63:0] r;
      logic [63:0] y;
      logic [63:0] z;
      logic [63:0] k2;
      longint      k;
      e1 = taylor(FX_ONE, 1'b0);
      einv = taylor(FX_ONE, 1'b1);
      if (x >= 0) begin
         k = x / FX_S;
      end else begin
         k = -((-x + FX_S - 1) / FX_S);
      end
      r = 64'(x - k * FX_S);
      y = taylor(r, 1'b0);
      for (longint j = 0; j < k; j++) begin
         y = qmul(y, e1);
      end
      for (longint j = 0; j > k; j--) begin
         y = qmul(y, einv);
      end
      k2 = y >> 30;
      z = taylor(y & FX_MASK, 1'b1);
      for (logic [63:0] m = 64'd0; m < k2; m++) begin
         z = qmul(z, einv);
      end
      return (z > FX_ONE) ? 64'd0 : FX_ONE - z;
   endfunction

   function automatic logic [63:0] mask_entry(input logic [63:0] pos, input int frac);
      logic [63:0] one;
      logic [63:0] f;
      logic [63:0] w;
      one = 64'd1 << frac;
      f = gompertz(longint'(pos) - 3 * FX_S);
      w = (f * one + FX_HALF) >> 30;
      if (w > one) begin
         w = one;
      end
      return w;
   endfunction

endpackage

@@ design/soft_threshold_mask_top.sv @@
// channel | ports                                   | direction | payload
// req     | req_tvalid req_tready req_tdata req_tlast | in      | amplitude, last_sample
// rsp     | rsp_tvalid rsp_tready rsp_tdata rsp_tlast | out     | weight, last_weight
// csr     | csr_valid csr_ready csr_index csr_data    | in      | register writes
//
// Eight register stages; one word per clock while rsp_tready stays high.
// Two constant multipliers for the divisions by three, the scale multiplier and the
// interpolation multiplier each sit in a stage of their own.
// Reset (synchronous) clears all stage valid bits and loads the register defaults.
// Each stage holds its word while the next one is full and stalled; bubbles close up.
`include "assert_macros.svh"

module soft_threshold_mask_top #(
   parameter int TABLE_ENTRIES = stm_pkg::TABLE_ENTRIES_DEF,
   parameter int WEIGHT_FRAC_BITS = stm_pkg::WEIGHT_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [stm_pkg::AMP_W-1:0]           req_tdata,  // amplitude[23:0]
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((WEIGHT_FRAC_BITS+8)/8)*8-1:0] rsp_tdata, // weight, zero fill
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [stm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [stm_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int WW = WEIGHT_FRAC_BITS + 1;
   localparam int RSP_W = ((WEIGHT_FRAC_BITS + 8) / 8) * 8;
   localparam int P_W = stm_pkg::T_W + $clog2(TABLE_ENTRIES + 1);

   logic [stm_pkg::THR_W-1:0] threshold_ff;
   logic [stm_pkg::SCALE_W-1:0] scale_ff;
   logic hard_mode_ff;

   logic front_valid, front_ready;
   stm_pkg::ctrl_type front_ctrl;
   logic [P_W-1:0] front_p;

   logic look_valid, look_ready;
   stm_pkg::ctrl_type look_ctrl;
   logic [WW-1:0] look_lo, look_diff;
   logic [stm_pkg::T_W-1:0] look_r;

   logic [WW-1:0] weight;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= stm_pkg::THRESHOLD_RST;
         scale_ff <= stm_pkg::SCALE_RST;
         hard_mode_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            stm_pkg::REG_THRESHOLD: threshold_ff <= csr_data[stm_pkg::THR_W-1:0];
            stm_pkg::REG_SCALE:     scale_ff <= csr_data[stm_pkg::SCALE_W-1:0];
            stm_pkg::REG_HARD_MODE: hard_mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   stm_front #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .P_W(P_W)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .in_valid(req_tvalid),
      .in_ready(req_tready),
      .amplitude($signed(req_tdata)),
      .last_sample(req_tlast),
      .threshold(threshold_ff),
      .scale(scale_ff),
      .hard_mode(hard_mode_ff),
      .out_valid(front_valid),
      .out_ready(front_ready),
      .out_ctrl(front_ctrl),
      .out_p(front_p)
   );

   stm_lookup #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS),
      .P_W(P_W),
      .WW(WW)
   ) u_lookup (
      .clock(clock),
      .reset(reset),
      .in_valid(front_valid),
      .in_ready(front_ready),
      .in_ctrl(front_ctrl),
      .in_p(front_p),
      .out_valid(look_valid),
      .out_ready(look_ready),
      .out_ctrl(look_ctrl),
      .out_lo(look_lo),
      .out_diff(look_diff),
      .out_r(look_r)
   );

   stm_interp #(
      .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS),
      .WW(WW)
   ) u_interp (
      .clock(clock),
      .reset(reset),
      .in_valid(look_valid),
      .in_ready(look_ready),
      .in_ctrl(look_ctrl),
      .in_lo(look_lo),
      .in_diff(look_diff),
      .in_r(look_r),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .weight(weight),
      .last_weight(rsp_tlast)
   );

   assign rsp_tdata = RSP_W'(weight);

   `ASSERT_NEVER(a_csr_stall, !csr_ready, "register port refused a write")

endmodule

@@ design/stm_front.sv @@
`include "assert_macros.svh"

module stm_front #(
   parameter int TABLE_ENTRIES = stm_pkg::TABLE_ENTRIES_DEF,
   parameter int P_W = stm_pkg::T_W + $clog2(TABLE_ENTRIES + 1)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic signed [stm_pkg::AMP_W-1:0]   amplitude,
   input  logic                               last_sample,
   input  logic [stm_pkg::THR_W-1:0]          threshold,
   input  logic [stm_pkg::SCALE_W-1:0]        scale,
   input  logic                               hard_mode,
   output logic                               out_valid,
   input  logic                               out_ready,
   output stm_pkg::ctrl_type                  out_ctrl,
   output logic [P_W-1:0]                     out_p
);

   localparam logic [63:0] P_MAX64 = 64'(TABLE_ENTRIES) * 64'd393216;
   localparam logic [P_W-1:0] P_MAX = P_MAX64[P_W-1:0];

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_ready, s2_ready, s3_ready;

   logic signed [stm_pkg::D_W-1:0] amp_ext;
   logic signed [stm_pkg::D_W-1:0] mag;
   logic signed [stm_pkg::D_W-1:0] d_in, d_ff;
   logic hit_in, hit1_ff, hit2_ff;
   logic hard1_ff, hard2_ff;
   logic last1_ff, last2_ff;

   logic signed [stm_pkg::X_W-1:0] x_in, x_ff;
   logic signed [stm_pkg::X_W-1:0] tsum;

   stm_pkg::ctrl_type ctrl_in, ctrl_ff;
   logic [P_W-1:0] p_in, p_ff;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_comb begin
      amp_ext = stm_pkg::D_W'(amplitude);
      mag = amp_ext[stm_pkg::D_W-1] ? -amp_ext : amp_ext;
      d_in = mag - $signed({2'b00, threshold});
      hit_in = !d_in[stm_pkg::D_W-1] && (d_in != '0);
   end

   assign x_in = d_ff * $signed({1'b0, scale});

   always_comb begin
      ctrl_in.last = last2_ff;
      ctrl_in.code = stm_pkg::CODE_TABLE;
      p_in = '0;
      tsum = x_ff + stm_pkg::X_LIMIT;
      if (hard2_ff) begin
         ctrl_in.code = hit2_ff ? stm_pkg::CODE_ONE : stm_pkg::CODE_ZERO;
      end else if (x_ff > stm_pkg::X_LIMIT) begin
         ctrl_in.code = stm_pkg::CODE_ONE;
      end else if (x_ff < stm_pkg::X_LIMIT_NEG) begin
         ctrl_in.code = stm_pkg::CODE_ZERO;
      end else begin
         p_in = P_W'(tsum[stm_pkg::T_W-1:0]) * P_W'(TABLE_ENTRIES);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         d_ff <= d_in;
         hit1_ff <= hit_in;
         hard1_ff <= hard_mode;
         last1_ff <= last_sample;
      end
      if (s2_ready) begin
         x_ff <= x_in;
         hit2_ff <= hit1_ff;
         hard2_ff <= hard1_ff;
         last2_ff <= last1_ff;
      end
      if (s3_ready) begin
         ctrl_ff <= ctrl_in;
         p_ff <= p_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_ctrl = ctrl_ff;
   assign out_p = p_ff;

   `ASSERT_NEVER(a_p_span, s3_valid_ff && (ctrl_ff.code == stm_pkg::CODE_TABLE) && (p_ff > P_MAX), "table position beyond last entry")
   `ASSERT_NEVER(a_p_idle, s3_valid_ff && (ctrl_ff.code != stm_pkg::CODE_TABLE) && (p_ff != '0), "table position set on saturated word")

endmodule

@@ design/stm_lookup.sv @@
`include "assert_macros.svh"

module stm_lookup #(
   parameter int TABLE_ENTRIES = stm_pkg::TABLE_ENTRIES_DEF,
   parameter int WEIGHT_FRAC_BITS = stm_pkg::WEIGHT_FRAC_BITS_DEF,
   parameter int P_W = stm_pkg::T_W + $clog2(TABLE_ENTRIES + 1),
   parameter int WW = WEIGHT_FRAC_BITS + 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  stm_pkg::ctrl_type           in_ctrl,
   input  logic [P_W-1:0]              in_p,
   output logic                        out_valid,
   input  logic                        out_ready,
   output stm_pkg::ctrl_type           out_ctrl,
   output logic [WW-1:0]               out_lo,
   output logic [WW-1:0]               out_diff,
   output logic [stm_pkg::T_W-1:0]     out_r
);

   localparam int I_W = $clog2(TABLE_ENTRIES + 1);
   localparam int Q_W = P_W - stm_pkg::SPAN_SHIFT;
   localparam int M1_W = Q_W + 1;
   localparam logic [63:0] M1_64 = (64'd1 << (Q_W + 2)) / 64'd3 + 64'd1;
   localparam logic [M1_W-1:0] M1 = M1_64[M1_W-1:0];
   localparam logic [I_W-1:0] I_LAST = I_W'(TABLE_ENTRIES);

   logic [WW-1:0] rom [0:TABLE_ENTRIES];

   for (genvar g = 0; g <= TABLE_ENTRIES; g++) begin : g_rom
      localparam logic [63:0] POS =
         (64'd6 * stm_pkg::FX_ONE * 64'(g) + 64'(TABLE_ENTRIES / 2)) / 64'(TABLE_ENTRIES);
      localparam logic [63:0] ENTRY = stm_pkg::mask_entry(POS, WEIGHT_FRAC_BITS);
      assign rom[g] = ENTRY[WW-1:0];
   end

   logic s4_valid_ff, s5_valid_ff;
   logic s4_ready, s5_ready;

   logic [Q_W-1:0] q_in, q_ff;
   logic [Q_W+M1_W-1:0] recip;
   logic [I_W-1:0] i_in, i_ff;
   logic [stm_pkg::SPAN_SHIFT-1:0] low_ff;
   stm_pkg::ctrl_type ctrl4_ff, ctrl5_ff;

   logic [Q_W-1:0] rem_full;
   logic [I_W-1:0] hi_idx;
   logic [WW-1:0] lo_val, hi_val;
   logic [WW-1:0] lo_ff, diff_in, diff_ff;
   logic [stm_pkg::T_W-1:0] r_in, r_ff;

   assign s5_ready = !s5_valid_ff || out_ready;
   assign s4_ready = !s4_valid_ff || s5_ready;
   assign in_ready = s4_ready;

   always_comb begin
      q_in = in_p[P_W-1:stm_pkg::SPAN_SHIFT];
      recip = (Q_W + M1_W)'(q_in) * (Q_W + M1_W)'(M1);
      i_in = recip[Q_W+2 +: I_W];
   end

   always_comb begin
      rem_full = q_ff - Q_W'(i_ff) * Q_W'(3);
      r_in = {rem_full[1:0], low_ff};
      hi_idx = (i_ff >= I_LAST) ? I_LAST : I_W'(i_ff + 1'b1);
      lo_val = rom[i_ff];
      hi_val = rom[hi_idx];
      diff_in = (hi_val >= lo_val) ? hi_val - lo_val : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (s4_ready) s4_valid_ff <= in_valid;
         if (s5_ready) s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready) begin
         q_ff <= q_in;
         i_ff <= i_in;
         low_ff <= in_p[stm_pkg::SPAN_SHIFT-1:0];
         ctrl4_ff <= in_ctrl;
      end
      if (s5_ready) begin
         lo_ff <= lo_val;
         diff_ff <= diff_in;
         r_ff <= r_in;
         ctrl5_ff <= ctrl4_ff;
      end
   end

   assign out_valid = s5_valid_ff;
   assign out_ctrl = ctrl5_ff;
   assign out_lo = lo_ff;
   assign out_diff = diff_ff;
   assign out_r = r_ff;

   `ASSERT_NEVER(a_index_range, s4_valid_ff && (i_ff > I_LAST), "table index beyond last entry")
   `ASSERT_NEVER(a_rem_range, s4_valid_ff && (rem_full > Q_W'(2)), "division by three left remainder above two")

endmodule

@@ design/stm_interp.sv @@
`include "assert_macros.svh"

module stm_interp #(
   parameter int WEIGHT_FRAC_BITS = stm_pkg::WEIGHT_FRAC_BITS_DEF,
   parameter int WW = WEIGHT_FRAC_BITS + 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  stm_pkg::ctrl_type           in_ctrl,
   input  logic [WW-1:0]               in_lo,
   input  logic [WW-1:0]               in_diff,
   input  logic [stm_pkg::T_W-1:0]     in_r,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [WW-1:0]               weight,
   output logic                        last_weight
);

   localparam int PR_W = WW + stm_pkg::T_W;
   localparam int V_W = PR_W + 1;
   localparam int Q2_W = V_W - stm_pkg::SPAN_SHIFT;
   localparam int M2_W = Q2_W + 1;
   localparam logic [63:0] M2_64 = (64'd1 << (Q2_W + 2)) / 64'd3 + 64'd1;
   localparam logic [M2_W-1:0] M2 = M2_64[M2_W-1:0];
   localparam logic [WW-1:0] W_ONE = WW'(1) << WEIGHT_FRAC_BITS;

   logic s6_valid_ff, s7_valid_ff, s8_valid_ff;
   logic s6_ready, s7_ready, s8_ready;

   stm_pkg::ctrl_type ctrl6_ff, ctrl7_ff;
   logic [WW-1:0] lo6_ff, lo7_ff;
   logic [PR_W-1:0] prod_in, prod_ff;
   logic [V_W-1:0] rnd;
   logic [Q2_W-1:0] q2_in, q2_ff;
   logic [Q2_W+M2_W-1:0] recip;
   logic [WW-1:0] w_in, w_ff;
   logic last_ff;

   assign s8_ready = !s8_valid_ff || out_ready;
   assign s7_ready = !s7_valid_ff || s8_ready;
   assign s6_ready = !s6_valid_ff || s7_ready;
   assign in_ready = s6_ready;

   assign prod_in = PR_W'(in_diff) * PR_W'(in_r);

   always_comb begin
      rnd = V_W'(prod_ff) + V_W'(stm_pkg::HALF_SPAN);
      q2_in = rnd[V_W-1:stm_pkg::SPAN_SHIFT];
   end

   always_comb begin
      recip = (Q2_W + M2_W)'(q2_ff) * (Q2_W + M2_W)'(M2);
      case (ctrl7_ff.code)
         stm_pkg::CODE_ONE:   w_in = W_ONE;
         stm_pkg::CODE_TABLE: w_in = lo7_ff + recip[Q2_W+2 +: WW];
         default:             w_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
         s8_valid_ff <= 1'b0;
      end else begin
         if (s6_ready) s6_valid_ff <= in_valid;
         if (s7_ready) s7_valid_ff <= s6_valid_ff;
         if (s8_ready) s8_valid_ff <= s7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s6_ready) begin
         prod_ff <= prod_in;
         lo6_ff <= in_lo;
         ctrl6_ff <= in_ctrl;
      end
      if (s7_ready) begin
         q2_ff <= q2_in;
         lo7_ff <= lo6_ff;
         ctrl7_ff <= ctrl6_ff;
      end
      if (s8_ready) begin
         w_ff <= w_in;
         last_ff <= ctrl7_ff.last;
      end
   end

   assign out_valid = s8_valid_ff;
   assign weight = w_ff;
   assign last_weight = last_ff;

   `ASSERT_NEVER(a_weight_range, s8_valid_ff && (w_ff > W_ONE), "weight above one")

endmodule
